// File: design/sm_pkg.sv
// Shared types and constants for the set median block.
// Holds the beat structs, the cell link struct and the control state type.
// No dependencies.
package sm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;
    localparam int COUNT_W  = 7;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_in;

    typedef struct packed {
        logic signed [MEDIAN_W-1:0] median_doubled;
        logic [COUNT_W-1:0]         count;
        logic                       overflow;
    } t_out;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       gt;
    } t_link;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PICK,
        ST_SUM
    } t_state;

endpackage

// File: design/sm_cell.sv
// One cell of the sorting chain: holds a single sample of the sorted set.
// Depends on sm_pkg for the link struct shared with its neighbors.
// A cell shifts in its left neighbor's value, takes the new sample, or holds.
module sm_cell (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic                               i_empty,
    input  logic signed [sm_pkg::SAMPLE_W-1:0] i_sample,
    input  sm_pkg::t_link                      i_left,
    output sm_pkg::t_link                      o_link
);
    import sm_pkg::*;

    logic signed [SAMPLE_W-1:0] r_value;
    logic signed [SAMPLE_W-1:0] n_value;
    logic                       w_gt;

    // An empty cell acts as a value larger than any sample.
    assign w_gt = i_empty || (r_value > i_sample);

    always_comb begin
        if (i_left.gt) begin
            n_value = i_left.value;
        end else if (w_gt) begin
            n_value = i_sample;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= n_value;
        end
    end

    assign o_link.value = r_value;
    assign o_link.gt    = w_gt;

endmodule

// File: design/set_median.sv
// Top level of the set median block: a chain of sorting cells and its control.
// Depends on sm_pkg and sm_cell.
//
// Usage: a beat on i_in is accepted at a rising edge with start high and busy
// low. Each beat carries one signed 32-bit sample and a last flag. Samples are
// inserted into a chain of MAX_SAMPLES cells that keeps them in ascending
// order; every cell compares itself with the broadcast sample and either
// shifts in its left neighbor, takes the sample, or holds, so one sample is
// placed per cycle while busy is low. Once the chain is full, further
// samples of the set are dropped and the overflow flag of the result is set.
// A beat without last gives no result and busy stays low.
// A beat with last gives one result beat on o_result, marked by o_done for
// exactly one cycle. The accepting edge inserts the sample and enters
// ST_PICK, which registers the middle cells; ST_SUM then adds them and
// registers the result together with o_done. busy is high in ST_PICK and
// ST_SUM and drops in the cycle o_done is high. The receiver cannot stall
// the result.
// Reset (synchronous, active low) empties the chain and clears the overflow
// flag; no clearing pass runs over the cells. A new set starts empty after
// every result.
module set_median #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  sm_pkg::t_in   i_in,
    output logic          o_done,
    output sm_pkg::t_out  o_result
);
    import sm_pkg::*;

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    t_state                     r_state, n_state;
    logic [CW-1:0]              r_fill, n_fill;
    logic                       r_ovf, n_ovf;
    logic signed [SAMPLE_W-1:0] r_lo, n_lo;
    logic signed [SAMPLE_W-1:0] r_hi, n_hi;
    logic [COUNT_W-1:0]         r_count, n_count;
    logic                       r_set_ovf, n_set_ovf;
    logic                       r_done, n_done;
    t_out                       r_result, n_result;

    logic                       w_accept;
    logic                       w_insert;
    logic [CW-1:0]              w_half;
    logic [CW-1:0]              w_half_m1;
    logic signed [SAMPLE_W-1:0] w_val  [MAX_SAMPLES];
    t_link                      w_link [MAX_SAMPLES];

    assign busy     = (r_state != ST_LOAD);
    assign w_accept = start && !busy;
    assign w_insert = w_accept && (r_fill < CW'(MAX_SAMPLES));

    for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
        t_link w_left;
        logic  w_empty;

        if (g == 0) begin : g_first
            assign w_left.value = '0;
            assign w_left.gt    = 1'b0;
        end else begin : g_rest
            assign w_left = w_link[g-1];
        end

        assign w_empty  = (r_fill <= CW'(g));
        assign w_val[g] = w_link[g].value;

        sm_cell u_cell (
            .i_clk    (i_clk),
            .i_en     (w_insert),
            .i_empty  (w_empty),
            .i_sample (i_in.sample),
            .i_left   (w_left),
            .o_link   (w_link[g])
        );
    end

    assign w_half    = r_fill >> 1;
    assign w_half_m1 = w_half - CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_fill  <= '0;
            r_ovf   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ovf   <= n_ovf;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_count   <= n_count;
        r_set_ovf <= n_set_ovf;
        r_result  <= n_result;
    end

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_ovf     = r_ovf;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_count   = r_count;
        n_set_ovf = r_set_ovf;
        n_done    = 1'b0;
        n_result  = r_result;
        unique case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    if (w_insert) begin
                        n_fill = r_fill + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.last) begin
                        n_state = ST_PICK;
                    end
                end
            end
            ST_PICK: begin
                n_hi = w_val[w_half[AW-1:0]];
                if (r_fill[0]) begin
                    n_lo = w_val[w_half[AW-1:0]];
                end else begin
                    n_lo = w_val[w_half_m1[AW-1:0]];
                end
                n_count   = COUNT_W'(r_fill);
                n_set_ovf = r_ovf;
                n_fill    = '0;
                n_ovf     = 1'b0;
                n_state   = ST_SUM;
            end
            ST_SUM: begin
                n_result.median_doubled = MEDIAN_W'(r_lo) + MEDIAN_W'(r_hi);
                n_result.count          = r_count;
                n_result.overflow       = r_set_ovf;
                n_done                  = 1'b1;
                n_state                 = ST_LOAD;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
